// ===== src/shared_bitmap_block_allocator_core_defines.svh =====
// Assertion macros shared by the allocator checker.
`ifndef SHARED_BITMAP_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define SHARED_BITMAP_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBBA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/sbba_pkg.sv =====
// Package with widths, constants and shared types of the block allocator.
package sbba_pkg;

   localparam int COUNT_W  = 4;
   localparam int OWNER_W  = 8;
   localparam int BITMAP_W = 32;
   localparam int OFFSET_W = 14;
   localparam int INDEX_W  = 5;

   // Runs must end below this block.
   localparam int RUN_LIMIT = 24;

   typedef struct packed {
      logic                hit;
      logic [BITMAP_W-1:0] want;
   } probe_type;

endpackage

// ===== src/sbba_if.sv =====
// Valid/ready channel interfaces for allocation requests and responses.
interface sbba_req_if;
   import sbba_pkg::*;

   logic                valid;
   logic                ready;
   logic [COUNT_W-1:0]  block_count;
   logic [OWNER_W-1:0]  owner_id;
   logic [BITMAP_W-1:0] peer_bitmap;

   modport source (output valid, block_count, owner_id, peer_bitmap, input ready);
   modport sink   (input valid, block_count, owner_id, peer_bitmap, output ready);
endinterface

interface sbba_rsp_if;
   import sbba_pkg::*;

   logic                valid;
   logic                ready;
   logic                granted;
   logic [OFFSET_W-1:0] byte_offset;
   logic [BITMAP_W-1:0] block_mask;

   modport source (output valid, granted, byte_offset, block_mask, input ready);
   modport sink   (input valid, granted, byte_offset, block_mask, output ready);
endinterface

// ===== src/sbba_probe.sv =====
// Window probe: builds the bitmap mask of one candidate run and tests it.
module sbba_probe (
   input  logic [sbba_pkg::COUNT_W-1:0]  count,
   input  logic [sbba_pkg::INDEX_W-1:0]  start,
   input  logic [sbba_pkg::BITMAP_W-1:0] free_bits,
   output sbba_pkg::probe_type           result
);
   import sbba_pkg::*;

   logic [BITMAP_W-1:0] top_ones;

   // Block b sits at bit 31-b, so a run of count blocks starting at block 0
   // is the top count bits; shifting right moves it to the start block.
   assign top_ones    = ~({BITMAP_W{1'b1}} >> count);
   assign result.want = top_ones >> start;
   assign result.hit  = ((free_bits & result.want) == result.want);

endmodule

// ===== src/shared_bitmap_block_allocator_core.sv =====
// Steps: the request is accepted in ST_IDLE, then one candidate window is probed per cycle
// (at most 31 for a single block, at most 22 for a run), then one owner-table entry is
// written per cycle for each granted block; the response beat is held in ST_DONE until taken.
// Only one request is in flight; a new one is taken after the response beat.
// Synchronous reset clears the host bitmap and control; owner table is not cleared.
module shared_bitmap_block_allocator_core #(
   parameter int POOL_BLOCKS = 32,
   parameter int BLOCK_SHIFT = 9,
   parameter int MAX_RUN     = 8
) (
   input  logic       clock,
   input  logic       reset,
   sbba_req_if.sink   req_ch,
   sbba_rsp_if.source rsp_ch
);
   import sbba_pkg::*;

   localparam int RUN_TOP = (POOL_BLOCKS < RUN_LIMIT) ? POOL_BLOCKS : RUN_LIMIT;
   localparam int SHIFT_W = INDEX_W + BLOCK_SHIFT;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_OWNER = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COUNT_W-1:0]  left_ff, left_in;
   logic [OWNER_W-1:0]  owner_ff, owner_in;
   logic [BITMAP_W-1:0] free_ff, free_in;
   logic [BITMAP_W-1:0] host_ff, host_in;
   logic [INDEX_W-1:0]  pos_ff, pos_in;
   logic                granted_ff, granted_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [BITMAP_W-1:0] mask_ff, mask_in;

   logic [OWNER_W-1:0]  owner_mem [2**INDEX_W];

   probe_type                   probe;
   logic                        single;
   logic                        last_pos;
   logic                        run_ok;
   logic [SHIFT_W-1:0]          pos_shift;
   logic [SHIFT_W+OFFSET_W-1:0] pos_wide;

   sbba_probe u_probe (
      .count     (count_ff),
      .start     (pos_ff),
      .free_bits (free_ff),
      .result    (probe)
   );

   assign single    = (count_ff == COUNT_W'(1));
   assign last_pos  = single ? (pos_ff == INDEX_W'(POOL_BLOCKS - 1))
                             : (pos_ff == INDEX_W'(1));
   assign run_ok    = (req_ch.block_count >= COUNT_W'(2))
                   && (req_ch.block_count <= COUNT_W'(MAX_RUN))
                   && (INDEX_W'(RUN_TOP) > {1'b0, req_ch.block_count});
   assign pos_shift = SHIFT_W'(pos_ff) << BLOCK_SHIFT;
   assign pos_wide  = {{OFFSET_W{1'b0}}, pos_shift};

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      left_in    = left_ff;
      owner_in   = owner_ff;
      free_in    = free_ff;
      host_in    = host_ff;
      pos_in     = pos_ff;
      granted_in = granted_ff;
      offset_in  = offset_ff;
      mask_in    = mask_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               count_in   = req_ch.block_count;
               owner_in   = req_ch.owner_id;
               free_in    = ~(host_ff ^ req_ch.peer_bitmap);
               granted_in = 1'b0;
               offset_in  = '0;
               mask_in    = '0;
               if (req_ch.block_count == COUNT_W'(1)) begin
                  pos_in   = INDEX_W'(1);
                  state_in = ST_SCAN;
               end else if (run_ok) begin
                  // Runs are tried from the highest start downward.
                  pos_in   = INDEX_W'(RUN_TOP) - {1'b0, req_ch.block_count};
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (probe.hit) begin
               host_in    = host_ff ^ probe.want;
               granted_in = 1'b1;
               offset_in  = pos_wide[OFFSET_W-1:0];
               mask_in    = probe.want;
               left_in    = count_ff;
               state_in   = ST_OWNER;
            end else if (last_pos) begin
               state_in = ST_DONE;
            end else if (single) begin
               pos_in = pos_ff + INDEX_W'(1);
            end else begin
               pos_in = pos_ff - INDEX_W'(1);
            end
         end
         ST_OWNER: begin
            // One owner entry per cycle, walking up from the first granted block.
            pos_in  = pos_ff + INDEX_W'(1);
            left_in = left_ff - COUNT_W'(1);
            if (left_ff == COUNT_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         host_ff  <= '0;
      end else begin
         state_ff <= state_in;
         host_ff  <= host_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      left_ff    <= left_in;
      owner_ff   <= owner_in;
      free_ff    <= free_in;
      pos_ff     <= pos_in;
      granted_ff <= granted_in;
      offset_ff  <= offset_in;
      mask_ff    <= mask_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OWNER) begin
         owner_mem[pos_ff] <= owner_ff;
      end
   end

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = (state_ff == ST_DONE);
   assign rsp_ch.granted     = granted_ff;
   assign rsp_ch.byte_offset = offset_ff;
   assign rsp_ch.block_mask  = mask_ff;

endmodule

// ===== src/sbba_checker.sv =====
// Port-level checker for the block allocator and its bind statement.
`include "shared_bitmap_block_allocator_core_defines.svh"

module sbba_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_granted,
   input logic [sbba_pkg::OFFSET_W-1:0] rsp_byte_offset,
   input logic [sbba_pkg::BITMAP_W-1:0] rsp_block_mask
);
   import sbba_pkg::*;

   // A failed request reports nothing but zeros.
   `SBBA_ASSERT_SAME(a_fail_zero, clock, reset, rsp_valid && !rsp_granted, (rsp_byte_offset == '0) && (rsp_block_mask == '0), "failed response carries nonzero fields")

   // A grant toggles at least one block and never block zero.
   `SBBA_ASSERT_SAME(a_grant_mask, clock, reset, rsp_valid && rsp_granted, (rsp_block_mask != '0) && !rsp_block_mask[BITMAP_W-1], "grant mask empty or includes block zero")

   // Only one request is in flight at a time.
   `SBBA_ASSERT_SAME(a_busy_resp, clock, reset, rsp_valid, !req_ready, "request taken while a response is pending")

   `SBBA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_block_mask), "stalled response beat changed")

endmodule

bind shared_bitmap_block_allocator_core sbba_checker u_sbba_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_granted     (rsp_ch.granted),
   .rsp_byte_offset (rsp_ch.byte_offset),
   .rsp_block_mask  (rsp_ch.block_mask)
);

// ===== sim/tb.sv =====
// Self-checking testbench for the shared bitmap block allocator core.
`timescale 1ns / 100ps

module tb;
   import sbba_pkg::*;

   localparam int RESET_CYCLES  = 11;
   localparam int IDLE_LIMIT    = 4000;
   localparam int DRAIN_CYCLES  = 60;
   localparam int RANDOM_ITEMS  = 1200;
   localparam int MAX_REPORTS   = 10;
   localparam int NUM_BLOCKS    = 32;
   localparam int LONGEST_RUN   = 8;
   localparam int SHIFT         = 9;

   typedef struct packed {
      logic [COUNT_W-1:0]  block_count;
      logic [OWNER_W-1:0]  owner_id;
      logic [BITMAP_W-1:0] peer_bitmap;
   } alloc_req_type;

   typedef struct packed {
      logic                granted;
      logic [OFFSET_W-1:0] byte_offset;
      logic [BITMAP_W-1:0] block_mask;
   } alloc_rsp_type;

   typedef enum int {
      FREE_NOISE, FREE_DENSE, FREE_SPARSE, FREE_RUN, FREE_EMPTY, FREE_HOLES
   } free_shape_type;

   logic clock;
   logic reset;

   sbba_req_if req_bus ();
   sbba_rsp_if rsp_bus ();

   shared_bitmap_block_allocator_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   alloc_req_type       pending_reqs[$];
   alloc_rsp_type       expected_rsps[$];
   logic [BITMAP_W-1:0] gen_host;
   logic [BITMAP_W-1:0] model_host;
   logic [OWNER_W-1:0]  owner_table [NUM_BLOCKS];
   int                  mismatches;
   int                  single_grants;
   int                  run_grants;
   int                  refusals;
   int                  idle_cycles;

   // Bitmap bits of blocks first..first+len-1; block b sits at bit 31-b.
   function automatic logic [BITMAP_W-1:0] blocks_mask(input int first, input int len);
      logic [BITMAP_W-1:0] m;
      m = '0;
      for (int i = 0; i < len; i++) begin
         if (first + i < NUM_BLOCKS) m[NUM_BLOCKS-1-(first+i)] = 1'b1;
      end
      return m;
   endfunction

   function automatic alloc_rsp_type predict_grant(input logic [BITMAP_W-1:0] host,
                                                  input alloc_req_type item);
      alloc_rsp_type       r;
      logic [BITMAP_W-1:0] freebits;
      logic [BITMAP_W-1:0] want;
      int                  n;
      r = '0;
      freebits = ~(host ^ item.peer_bitmap);
      n = item.block_count;
      if (n == 1) begin
         for (int b = 1; b < NUM_BLOCKS; b++) begin
            if (freebits[NUM_BLOCKS-1-b]) begin
               r.granted = 1'b1;
               r.byte_offset = OFFSET_W'(b << SHIFT);
               r.block_mask = blocks_mask(b, 1);
               return r;
            end
         end
      end else if (n >= 2 && n <= LONGEST_RUN && RUN_LIMIT > n) begin
         for (int s = RUN_LIMIT - n; s >= 1; s--) begin
            want = blocks_mask(s, n);
            if ((freebits & want) == want) begin
               r.granted = 1'b1;
               r.byte_offset = OFFSET_W'(s << SHIFT);
               r.block_mask = want;
               return r;
            end
         end
      end
      return r;
   endfunction

   task automatic push_raw(input int count, input int owner,
                           input logic [BITMAP_W-1:0] peer);
      alloc_req_type item;
      alloc_rsp_type r;
      item.block_count = COUNT_W'(count);
      item.owner_id = OWNER_W'(owner);
      item.peer_bitmap = peer;
      pending_reqs.push_back(item);
      // The generator tracks the host bitmap so it can aim free patterns.
      r = predict_grant(gen_host, item);
      gen_host = gen_host ^ r.block_mask;
   endtask

   task automatic push_free(input int count, input int owner,
                            input logic [BITMAP_W-1:0] freebits);
      push_raw(count, owner, gen_host ^ ~freebits);
   endtask

   initial clock = 1'b0;

   always #5 clock = ~clock;

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.block_count = '0;
      req_bus.owner_id = '0;
      req_bus.peer_bitmap = '0;
      rsp_bus.ready = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
   end

   // Stimulus and end of run.
   initial begin
      free_shape_type      shape;
      logic [BITMAP_W-1:0] freebits;
      int                  count;
      int                  first;
      gen_host = '0;

      // Bad counts with everything free.
      push_free(0, 8'h00, '1);
      push_free(9, 8'hff, '1);
      push_free(15, 8'h5a, '1);
      // Single block and runs of every length on a fully free pool.
      push_free(1, 8'h01, '1);
      for (int n = 2; n <= LONGEST_RUN; n++) push_free(n, n * 17, '1);
      // Only block zero looks free.
      push_free(1, 8'h33, blocks_mask(0, 1));
      push_free(2, 8'h34, blocks_mask(0, 1));
      // Nothing free.
      push_free(1, 8'h44, '0);
      // Only the last block free gives the widest offset.
      push_free(1, 8'hff, blocks_mask(31, 1));
      // Runs that fit exactly at the bottom and at the top of the run window.
      push_free(8, 8'h80, blocks_mask(1, 8));
      push_free(8, 8'h81, blocks_mask(16, 8));
      // Free blocks only above the run window.
      push_free(2, 8'h82, blocks_mask(24, 8));
      push_free(1, 8'h83, blocks_mask(24, 8));
      // Raw peer extremes.
      push_raw(1, 8'h00, 32'h0000_0000);
      push_raw(3, 8'hff, 32'hffff_ffff);

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         case ($urandom_range(0, 99)) inside
            [0:9]:   shape = FREE_NOISE;
            [10:24]: shape = FREE_DENSE;
            [25:39]: shape = FREE_SPARSE;
            [40:74]: shape = FREE_RUN;
            [75:79]: shape = FREE_EMPTY;
            default: shape = FREE_HOLES;
         endcase
         count = ($urandom_range(0, 99) < 85) ? $urandom_range(1, LONGEST_RUN)
                                              : (($urandom_range(0, 3) == 0) ? 0
                                                 : $urandom_range(LONGEST_RUN + 1, 15));
         first = $urandom_range(0, NUM_BLOCKS - 1);
         case (shape)
            FREE_DENSE:  freebits = $urandom | $urandom;
            FREE_SPARSE: freebits = $urandom & $urandom & $urandom;
            FREE_RUN:    freebits = blocks_mask(first, $urandom_range(1, 10))
                                    | ($urandom & $urandom & $urandom & $urandom);
            FREE_EMPTY:  freebits = ($urandom_range(0, 1) == 0) ? '0 : blocks_mask(0, 1);
            FREE_HOLES:  freebits = ~(blocks_mask(first, 1)
                                      | blocks_mask($urandom_range(0, 31), 2));
            default:     freebits = $urandom;
         endcase
         if (shape == FREE_NOISE) push_raw(count, $urandom_range(0, 255), $urandom);
         else push_free(count, $urandom_range(0, 255), freebits);
      end

      @(negedge reset);
      while (pending_reqs.size() != 0) @(posedge clock);
      @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d responses: %0d single-block grants, %0d run grants, %0d refusals.",
               single_grants + run_grants + refusals, single_grants, run_grants, refusals);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches, expected_rsps.size());
         $display("simulation failed");
      end
      $finish;
   end

   // Request driver: bursts of random length separated by random gaps.
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) pending_reqs.delete(0);
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (gap_left != 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_bus.valid <= 1'b1;
               req_bus.block_count <= pending_reqs[0].block_count;
               req_bus.owner_id <= pending_reqs[0].owner_id;
               req_bus.peer_bitmap <= pending_reqs[0].peer_bitmap;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response sink: one of three stall modes, picked again at random whenever stall_phase wraps.
   int stall_mode;
   int stall_phase;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_mode = 0;
         stall_phase = 0;
      end else begin
         stall_phase++;
         if (stall_phase == 64) begin
            stall_phase = 0;
            stall_mode = $urandom_range(0, 2);
         end
         case (stall_mode)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= ($urandom_range(0, 1) == 1);
            default: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Monitor: checks each response beat, then predicts for each request beat.
   always @(posedge clock) begin
      alloc_req_type item;
      alloc_rsp_type want;
      alloc_rsp_type got;
      if (reset) begin
         model_host = '0;
         mismatches = 0;
         single_grants = 0;
         run_grants = 0;
         refusals = 0;
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (rsp_bus.valid && rsp_bus.ready) begin
            idle_cycles = 0;
            got.granted = rsp_bus.granted;
            got.byte_offset = rsp_bus.byte_offset;
            got.block_mask = rsp_bus.block_mask;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected response beat: granted=%0b offset=%0d mask=%h",
                           got.granted, got.byte_offset, got.block_mask);
            end else begin
               want = expected_rsps.pop_front();
               if (got.granted !== want.granted || got.byte_offset !== want.byte_offset
                   || got.block_mask !== want.block_mask) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("mismatch: exp g=%0b off=%0d mask=%h, got g=%0b off=%0d mask=%h",
                              want.granted, want.byte_offset, want.block_mask,
                              got.granted, got.byte_offset, got.block_mask);
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            idle_cycles = 0;
            item.block_count = req_bus.block_count;
            item.owner_id = req_bus.owner_id;
            item.peer_bitmap = req_bus.peer_bitmap;
            want = predict_grant(model_host, item);
            model_host = model_host ^ want.block_mask;
            for (int b = 0; b < NUM_BLOCKS; b++) begin
               if (want.block_mask[NUM_BLOCKS-1-b]) owner_table[b] = item.owner_id;
            end
            if (!want.granted) refusals++;
            else if (item.block_count == 1) single_grants++;
            else run_grants++;
            expected_rsps.push_back(want);
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("no handshake for %0d cycles, %0d responses outstanding",
                     IDLE_LIMIT, expected_rsps.size());
            $display("simulation failed");
            $finish;
         end
      end
   end

endmodule
